// File: rtl/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Types and codes shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package fdf_pkg;

   localparam int unsigned MinFrameLen = 4;
   localparam int unsigned HdrBytes    = 4;

   typedef enum logic [1:0] {
      ST_PAYLOAD = 2'd0,
      ST_OK      = 2'd1,
      ST_ERROR   = 2'd2,
      ST_SHORT   = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      REG_START_MARKER = 8'd0,
      REG_END_MARKER   = 8'd1,
      REG_MIN_LENGTH   = 8'd2,
      REG_MAX_LENGTH   = 8'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] min_length;
      logic [7:0] max_length;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic [7:0] msg_id;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] body_len;
      logic       last;
   } rsp_type;

endpackage

// File: rtl/fdf_step.sv
// ----------------------------------------------------------------------------
// fdf_step
// Frame parser state and next-word logic: one byte per step, at most one
// result word out.
// ----------------------------------------------------------------------------
module fdf_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic             buffer_end,
   input  fdf_pkg::cfg_type cfg,
   output logic             emit,
   output fdf_pkg::rsp_type res
);

   typedef enum logic [2:0] {
      PH_START,
      PH_LEN,
      PH_ID,
      PH_PAYLOAD,
      PH_END
   } phase_type;

   localparam logic [7:0] MinLen = 8'(fdf_pkg::MinFrameLen);
   localparam logic [7:0] Hdr    = 8'(fdf_pkg::HdrBytes);

   phase_type  phase_ff, phase_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] lo_len;
   logic [8:0] count_sum;

   assign lo_len    = (cfg.min_length < MinLen) ? MinLen : cfg.min_length;
   assign count_sum = {1'b0, count_ff} + 9'd1 + {1'b0, Hdr};

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      count_in = count_ff;
      emit     = 1'b0;
      res      = '{status: fdf_pkg::ST_PAYLOAD, msg_id: 8'd0, payload_byte: 8'd0,
                   payload_index: 8'd0, body_len: 8'd0, last: 1'b0};
      case (phase_ff)
         PH_START: begin
            if (rx_byte != cfg.start_marker) begin
               emit       = 1'b1;
               res.status = fdf_pkg::ST_ERROR;
               res.last   = 1'b1;
            end else begin
               len_in   = 8'd0;
               id_in    = 8'd0;
               count_in = 8'd0;
               if (buffer_end) begin
                  emit       = 1'b1;
                  res.status = fdf_pkg::ST_SHORT;
                  res.last   = 1'b1;
               end else begin
                  phase_in = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (rx_byte < lo_len || rx_byte > cfg.max_length) begin
               emit       = 1'b1;
               res.status = fdf_pkg::ST_ERROR;
               res.last   = 1'b1;
               phase_in   = PH_START;
            end else begin
               len_in = rx_byte;
               if (buffer_end) begin
                  emit       = 1'b1;
                  res.status = fdf_pkg::ST_SHORT;
                  res.last   = 1'b1;
                  phase_in   = PH_START;
               end else begin
                  phase_in = PH_ID;
               end
            end
         end
         PH_ID: begin
            id_in    = rx_byte;
            count_in = 8'd0;
            if (buffer_end) begin
               emit       = 1'b1;
               res.status = fdf_pkg::ST_SHORT;
               res.msg_id = rx_byte;
               res.last   = 1'b1;
               phase_in   = PH_START;
            end else begin
               phase_in = (len_ff > MinLen) ? PH_PAYLOAD : PH_END;
            end
         end
         PH_PAYLOAD: begin
            emit       = 1'b1;
            res.msg_id = id_ff;
            if (buffer_end) begin
               res.status = fdf_pkg::ST_SHORT;
               res.last   = 1'b1;
               phase_in   = PH_START;
            end else begin
               res.payload_byte  = rx_byte;
               res.payload_index = count_ff;
               count_in          = count_ff + 8'd1;
               if (count_sum >= {1'b0, len_ff}) begin
                  phase_in = PH_END;
               end
            end
         end
         PH_END: begin
            emit       = 1'b1;
            res.msg_id = id_ff;
            res.last   = 1'b1;
            phase_in   = PH_START;
            if (rx_byte != cfg.end_marker) begin
               res.status = fdf_pkg::ST_ERROR;
            end else begin
               res.status   = fdf_pkg::ST_OK;
               res.body_len = len_ff - Hdr;
            end
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         len_ff   <= 8'd0;
         id_ff    <= 8'd0;
         count_ff <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/frame_deframer_sob_len_id_eob.sv
// ----------------------------------------------------------------------------
// frame_deframer_sob_len_id_eob
// Length-prefixed frame deframer: start, length, id, payload, end byte.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes the input register, then the parser and the result register.
// Throughput: 1 word per cycle while the result side does not stall; the parser state updates on each step.
// Input register and result register decouple both sides; req_tready stays
//   high while the result register is taken or empty.
// Reset: synchronous, active high; parser waits for a start byte, registers
//   return to their defaults (markers 0, min length 4, max length 64).
module frame_deframer_sob_len_id_eob (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] msg_id, [15:8] payload_byte,
                                    // [23:16] payload_index, [31:24] body_len
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   fdf_pkg::cfg_type cfg_ff;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             out_valid_ff;
   fdf_pkg::rsp_type out_ff;

   logic             step;
   logic             emit;
   fdf_pkg::rsp_type res;

   assign csr_ready  = 1'b1;
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= 8'd0;
         cfg_ff.end_marker   <= 8'd0;
         cfg_ff.min_length   <= 8'd4;
         cfg_ff.max_length   <= 8'd64;
      end else if (csr_valid) begin
         case (csr_index)
            fdf_pkg::REG_START_MARKER: cfg_ff.start_marker <= csr_data;
            fdf_pkg::REG_END_MARKER:   cfg_ff.end_marker   <= csr_data;
            fdf_pkg::REG_MIN_LENGTH:   cfg_ff.min_length   <= csr_data;
            fdf_pkg::REG_MAX_LENGTH:   cfg_ff.max_length   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   fdf_step u_step (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .buffer_end (in_last_ff),
      .cfg        (cfg_ff),
      .emit       (emit),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.body_len, out_ff.payload_index,
                        out_ff.payload_byte, out_ff.msg_id};
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;

   a_last_marks_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != fdf_pkg::ST_PAYLOAD)))
      else $error("last flag disagrees with status");

   a_size_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != fdf_pkg::ST_OK) |-> (rsp_tdata[31:24] == 8'd0))
      else $error("payload size set on a non-ok word");

   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a full result register");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_byte_ff)
                                   && $stable(in_last_ff)))
      else $error("held input word lost");

endmodule

// File: tb/frame_deframer_sob_len_id_eob_checker.sv
// ----------------------------------------------------------------------------
// frame_deframer_sob_len_id_eob_checker
// Watches the byte, result and register channels of the frame deframer,
// tracks the frame parser and its registers on its own, and compares every
// result word field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module frame_deframer_sob_len_id_eob_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam logic [7:0] DefaultMaxLength = 8'd64;

   typedef enum logic [2:0] {
      PH_WAIT_START,
      PH_LENGTH,
      PH_MSG_ID,
      PH_PAYLOAD,
      PH_END_BYTE
   } parse_phase_type;

   fdf_pkg::cfg_type regs;
   parse_phase_type  phase;
   logic [7:0]       frame_len;
   logic [7:0]       frame_id;
   logic [7:0]       payload_cnt;
   fdf_pkg::rsp_type expected_words[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // One stream byte through the parser; returns 1 when it yields a word.
   function automatic bit deframe_byte(input logic [7:0] b, input logic buf_end,
                                       output fdf_pkg::rsp_type w);
      bit         has_word;
      logic [7:0] lo;
      w        = '0;
      w.status = fdf_pkg::ST_ERROR;
      w.last   = 1'b1;
      has_word = 1'b1;
      case (phase)
         PH_WAIT_START: begin
            if (b == regs.start_marker) begin
               frame_len   = '0;
               frame_id    = '0;
               payload_cnt = '0;
               if (buf_end) begin
                  w.status = fdf_pkg::ST_SHORT;
               end else begin
                  has_word = 1'b0;
                  phase    = PH_LENGTH;
               end
            end
         end
         PH_LENGTH: begin
            lo = (regs.min_length < fdf_pkg::MinFrameLen) ?
                 8'(fdf_pkg::MinFrameLen) : regs.min_length;
            if (b >= lo && b <= regs.max_length) begin
               frame_len = b;
               if (buf_end) begin
                  w.status = fdf_pkg::ST_SHORT;
               end else begin
                  has_word = 1'b0;
                  phase    = PH_MSG_ID;
               end
            end
         end
         PH_MSG_ID: begin
            frame_id    = b;
            payload_cnt = '0;
            w.msg_id    = b;
            if (buf_end) begin
               w.status = fdf_pkg::ST_SHORT;
            end else begin
               has_word = 1'b0;
               phase    = (frame_len > fdf_pkg::MinFrameLen) ? PH_PAYLOAD : PH_END_BYTE;
            end
         end
         PH_PAYLOAD: begin
            w.msg_id = frame_id;
            if (buf_end) begin
               w.status = fdf_pkg::ST_SHORT;
            end else begin
               w.status        = fdf_pkg::ST_PAYLOAD;
               w.payload_byte  = b;
               w.payload_index = payload_cnt;
               w.last          = 1'b0;
               payload_cnt     = payload_cnt + 8'd1;
               if (payload_cnt + fdf_pkg::HdrBytes >= frame_len) phase = PH_END_BYTE;
            end
         end
         default: begin
            w.msg_id = frame_id;
            if (b == regs.end_marker) begin
               w.status   = fdf_pkg::ST_OK;
               w.body_len = frame_len - 8'(fdf_pkg::HdrBytes);
            end
         end
      endcase
      // any final word sends the parser back to hunting for a start byte
      if (has_word && w.last) phase = PH_WAIT_START;
      return has_word;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      fdf_pkg::rsp_type want;
      fdf_pkg::rsp_type next_word;
      if (reset) begin
         regs = '{start_marker: 8'd0, end_marker: 8'd0,
                  min_length: 8'(fdf_pkg::MinFrameLen), max_length: DefaultMaxLength};
         phase       = PH_WAIT_START;
         frame_len   = '0;
         frame_id    = '0;
         payload_cnt = '0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual status %0h data %h last %b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_tuser));
               check_field("msg_id", want.msg_id, rsp_tdata[7:0]);
               check_field("payload_byte", want.payload_byte, rsp_tdata[15:8]);
               check_field("payload_index", want.payload_index, rsp_tdata[23:16]);
               check_field("body_len", want.body_len, rsp_tdata[31:24]);
               check_field("last", 8'(want.last), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            if (deframe_byte(req_tdata, req_tlast, next_word))
               expected_words.push_back(next_word);
         end
         if (csr_valid && csr_ready) begin
            case (fdf_pkg::reg_index_type'(csr_index))
               fdf_pkg::REG_START_MARKER: regs.start_marker = csr_data;
               fdf_pkg::REG_END_MARKER:   regs.end_marker   = csr_data;
               fdf_pkg::REG_MIN_LENGTH:   regs.min_length   = csr_data;
               fdf_pkg::REG_MAX_LENGTH:   regs.max_length   = csr_data;
               default: ;
            endcase
         end
      end
      pending = expected_words.size();
   end

endmodule

// File: tb/tb_frame_deframer_sob_len_id_eob.sv
// ----------------------------------------------------------------------------
// tb_frame_deframer_sob_len_id_eob
// Drives the frame deframer with random frame streams and directed frames
// (random streams: clean, corrupted, truncated, noise) under several register
// settings, with bursty input and a stalling result side. The checker
// module beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_frame_deframer_sob_len_id_eob;

   localparam int unsigned CycleLimit = 300000;
   localparam int unsigned HoldCycles = 300;

   typedef enum int unsigned {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_PATTERN
   } rx_mode_type;

   typedef enum int unsigned {
      FR_CLEAN,
      FR_BAD_START,
      FR_BAD_LEN,
      FR_BAD_END,
      FR_CUT_FLAG,
      FR_CUT_SILENT,
      FR_NOISE
   } frame_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   int unsigned fail_count;
   int unsigned pending;

   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;
   bit          hold_arm = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int unsigned rx_mode_left = 0;
   logic [7:0]  rx_mask = '0;

   logic [7:0]  cur_start = 8'd0;
   logic [7:0]  cur_end = 8'd0;
   logic [7:0]  cur_min = 8'(fdf_pkg::MinFrameLen);
   logic [7:0]  cur_max = 8'd64;

   logic [8:0]  directed_words[$] = '{
      9'h0FF,                                  // wrong start byte
      9'h0A5, 9'h003,                          // length below 4, min set lower
      9'h0A5, 9'h005, 9'h011, 9'h0FF, 9'h05A,  // one payload byte, ok
      9'h0A5, 9'h004, 9'h022, 9'h000,          // wrong end byte
      9'h1A5,                                  // buffer end on start byte
      9'h1FF,                                  // wrong start with buffer end
      9'h0A5, 9'h107,                          // range error beats buffer end
      9'h0A5, 9'h006, 9'h033, 9'h000, 9'h1C3,  // buffer end on payload
      9'h0A5, 9'h004, 9'h144,                  // buffer end on id
      9'h0A5, 9'h004, 9'h055, 9'h15A           // buffer end on end byte
   };

   frame_deframer_sob_len_id_eob uut (.*);

   frame_deframer_sob_len_id_eob_checker checker_i (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL frame_deframer_sob_len_id_eob");
         $finish;
      end
   end

   // result side: changing stall patterns, plus one long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 128);
            rx_mask      = 8'($urandom);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_tready <= rx_mask[0];
               rx_mask = {rx_mask[0], rx_mask[7:1]};
            end
         endcase
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [7:0] b, input logic lst);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] s, input logic [7:0] e,
                             input logic [7:0] mn, input logic [7:0] mx);
      write_reg(fdf_pkg::REG_START_MARKER, s);
      write_reg(fdf_pkg::REG_END_MARKER, e);
      write_reg(fdf_pkg::REG_MIN_LENGTH, mn);
      write_reg(fdf_pkg::REG_MAX_LENGTH, mx);
      // index past the register file, must be ignored
      write_reg(8'($urandom_range(4, 255)), 8'($urandom));
      csr_valid <= 1'b0;
      cur_start = s;
      cur_end   = e;
      cur_min   = mn;
      cur_max   = mx;
   endtask

   task automatic send_frame();
      logic [7:0]     q[$];
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    len;
      int unsigned    n;
      int             flag_pos;
      int unsigned    r;
      frame_kind_type kind;
      lo = (cur_min < fdf_pkg::MinFrameLen) ? fdf_pkg::MinFrameLen : cur_min;
      hi = cur_max;
      if (lo > hi || $urandom_range(0, 15) == 0) len = $urandom_range(0, 255);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(lo, hi);
      else len = $urandom_range(lo, (hi < lo + 6) ? hi : lo + 6);
      q.push_back(cur_start);
      q.push_back(8'(len));
      q.push_back(8'($urandom));
      for (int i = 4; i < int'(len); i++) q.push_back(8'($urandom));
      q.push_back(cur_end);
      r = $urandom_range(0, 19);
      case (r)
         0:       kind = FR_BAD_START;
         1:       kind = FR_BAD_LEN;
         2:       kind = FR_BAD_END;
         3, 4:    kind = FR_CUT_FLAG;
         5:       kind = FR_CUT_SILENT;
         6:       kind = FR_NOISE;
         default: kind = FR_CLEAN;
      endcase
      n        = q.size();
      flag_pos = -1;
      case (kind)
         FR_BAD_START: q[0] = q[0] ^ 8'($urandom_range(1, 255));
         FR_BAD_LEN:   q[1] = 8'($urandom);
         FR_BAD_END:   q[n-1] = q[n-1] ^ 8'($urandom_range(1, 255));
         FR_CUT_FLAG: begin
            flag_pos = $urandom_range(0, n - 1);
            n = flag_pos + 1;
         end
         FR_CUT_SILENT: n = $urandom_range(1, n - 1);
         FR_NOISE: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < int'(n); i++) q[i] = 8'($urandom);
            if ($urandom_range(0, 1) == 0) flag_pos = $urandom_range(0, n - 1);
         end
         default: if ($urandom_range(0, 7) == 0) flag_pos = n - 1;
      endcase
      for (int i = 0; i < int'(n); i++) send_word(q[i], i == flag_pos);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      target = words_sent + count;
      while (words_sent < target) send_frame();
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      run_random(100);
      drain();
      set_config(8'hA5, 8'h5A, 8'd2, 8'd6);
      foreach (directed_words[i]) send_word(directed_words[i][7:0], directed_words[i][8]);
      drain();
      set_config(8'hFF, 8'h00, 8'd4, 8'd255);
      run_random(100);
      drain();
      set_config(8'h00, 8'hFF, 8'd255, 8'd255);
      run_random(60);
      drain();
      set_config(8'($urandom), 8'($urandom), 8'd0, 8'd4);
      run_random(120);
      drain();
      set_config(8'($urandom), 8'($urandom), 8'd200, 8'd100);
      run_random(100);
      drain();
      set_config(8'($urandom), 8'($urandom), 8'($urandom_range(4, 20)),
                 8'($urandom_range(20, 80)));
      hold_arm = 1'b1;
      run_random(150);
      drain();
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_random(100);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("PASS frame_deframer_sob_len_id_eob");
      end else begin
         $display("FAIL frame_deframer_sob_len_id_eob");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/fdf_pkg.sv
rtl/fdf_step.sv
rtl/frame_deframer_sob_len_id_eob.sv
tb/frame_deframer_sob_len_id_eob_checker.sv
tb/tb_frame_deframer_sob_len_id_eob.sv
